// ===== sv/cpu_usage_window_slope_monitor_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the CPU usage window slope monitor
// Concurrent checks that disappear in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CPU_USAGE_WINDOW_SLOPE_MONITOR_ASSERT_SVH
`define CPU_USAGE_WINDOW_SLOPE_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge out of reset.
`define CUWSM_ASSERT(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// The condition must never be true out of reset.
`define CUWSM_NEVER(lbl, clk_s, rst_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);

`else

`define CUWSM_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define CUWSM_NEVER(lbl, clk_s, rst_s, cond, msg)

`endif

`endif

// ===== sv/cuwsm_pkg.sv =====
// ----------------------------------------------------------------------------
// cuwsm_pkg
// Types, widths and constants shared by the slope monitor modules.
// ----------------------------------------------------------------------------
package cuwsm_pkg;

	// Field widths of the input and result beats.
	localparam int USAGE_W   = 40;
	localparam int ELAPSED_W = 32;
	localparam int FREQ_W    = 24;
	localparam int SUM_W     = 48;
	localparam int COUNT_W   = 16;
	localparam int AVG_W     = 24;
	localparam int RATE_W    = 32;
	localparam int PCT_W     = 16;
	localparam int SLOPE_W   = 32;
	localparam int WLEN_W    = 5;

	localparam int IN_DATA_W  = 96;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 152;
	localparam int OUT_USER_W = 3;

	// Result flag positions in the master tuser.
	localparam int UB_CLOSED = 0;
	localparam int UB_SLOPE  = 1;
	localparam int UB_ERROR  = 2;

	// Command codes.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLOSE  = 1'b1;

	// Window defaults.
	localparam int MAX_WINDOW_DEF = 16;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd8;

	// Shared multiplier and iterative divider.
	localparam int MUL_W  = 32;
	localparam int PROD_W = 64;
	localparam int DIV_DVW = 72;
	localparam int DIV_DSW = 48;

	// Window fit sums; sized for windows up to 64 entries.
	localparam int FIT_W = 32;
	localparam int NUM_W = 40;

	// Scaling constants.
	localparam logic [MUL_W-1:0] US_PER_S    = 32'd1000000;
	localparam logic [MUL_W-1:0] RECIP_100   = 32'h51EB851F;
	localparam int               RECIP_SHIFT = 37;
	localparam logic [MUL_W-1:0] CENTI       = 32'd100;
	localparam int               Q16_SHIFT   = 17;

	// One decoded item between front and back.
	typedef struct packed {
		logic                 cmd;
		logic [USAGE_W-1:0]   usage;
		logic [ELAPSED_W-1:0] elapsed;
		logic [FREQ_W-1:0]    freq;
		logic                 elapsed_zero;
	} item_t;

	// Status of the iterative divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Sequencer states of the back end.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_S_MLO,
		ST_S_MHI,
		ST_S_SUM,
		ST_S_WAIT,
		ST_S_UPD,
		ST_C_AVG,
		ST_C_AWAIT,
		ST_C_MLO,
		ST_C_MHI,
		ST_C_RSUM,
		ST_C_RWAIT,
		ST_C_PCT0,
		ST_C_PCT1,
		ST_C_PUSH,
		ST_C_CHK,
		ST_W_RD,
		ST_W_MUL,
		ST_W_ACC,
		ST_F_NUM0,
		ST_F_NUM1,
		ST_F_DEN0,
		ST_F_DEN1,
		ST_F_CHK,
		ST_F_DMUL,
		ST_F_DIV,
		ST_F_WAIT,
		ST_OUT
	} back_state_t;

endpackage

// ===== sv/cpu_usage_window_slope_monitor.sv =====
// ----------------------------------------------------------------------------
// cpu_usage_window_slope_monitor
// Busy-time accounting with a least-squares slope over recent percentages.
// ----------------------------------------------------------------------------
// s_axis carries one item per beat: tuser[0] is the command (sample or period
// close); m_axis returns exactly one result beat per input beat, in order.
// cfg writes the window length; write it only while no item is in flight.
// Items run one at a time through a sequencer that shares one 32x32 multiplier
// and one 72-bit restoring divider (one quotient bit a cycle). The next item
// is taken only after the result of the previous one is loaded into the
// output register; the input register and a two-entry queue let beats
// arrive while an earlier item is in work.
// Reset clears the accumulators, the window head and fill, and sets the
// window length to 8; window contents are not cleared.
// When m_axis_tready is low the result waits in the output register, the
// sequencer holds, the queue fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module cpu_usage_window_slope_monitor import cuwsm_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Slave stream.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata: usage_counter_us[39:0], elapsed_us[71:40], core_freq_khz[95:72]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: command[0]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	// Master stream.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata: avg_freq_khz[23:0], busy_us[71:24], busy_rate[103:72],
	//        percent_centi[119:104], slope_q16[151:120]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// tuser: period_closed[0], slope_valid[1], div_error[2]
	output logic [OUT_USER_W-1:0] m_axis_tuser,
	// Configuration write channel: window_length.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [WLEN_W-1:0]     cfg_data
);

	logic              push, full, pop, not_empty;
	item_t             push_item, pop_item;
	logic [WLEN_W-1:0] wlen_q;

	// Window length register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			wlen_q <= cfg_data;
		end
	end

	cuwsm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.push_item     (push_item),
		.full          (full)
	);

	cuwsm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_item  (pop_item)
	);

	cuwsm_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.not_empty     (not_empty),
		.pop_item      (pop_item),
		.pop           (pop),
		.window_length (wlen_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== sv/cuwsm_front.sv =====
// ----------------------------------------------------------------------------
// cuwsm_front
// Accepts input beats, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module cuwsm_front import cuwsm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	input  logic [IN_USER_W-1:0] s_axis_tuser,
	output logic                 push,
	output item_t                push_item,
	input  logic                 full
);

	logic  hold_q;
	item_t item_q;
	item_t dec;

	// Unpack and classify the beat.
	always_comb begin
		dec.cmd          = s_axis_tuser[0];
		dec.usage        = s_axis_tdata[USAGE_W-1:0];
		dec.elapsed      = s_axis_tdata[USAGE_W+ELAPSED_W-1:USAGE_W];
		dec.freq         = s_axis_tdata[IN_DATA_W-1:USAGE_W+ELAPSED_W];
		dec.elapsed_zero = (dec.elapsed == '0);
	end

	assign push          = hold_q && !full;
	assign push_item     = item_q;
	assign s_axis_tready = !hold_q || push;

	// Holding register for one beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			hold_q <= 1'b1;
		end else if (push) begin
			hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_q <= dec;
		end
	end

endmodule

// ===== sv/cuwsm_fifo.sv =====
// ----------------------------------------------------------------------------
// cuwsm_fifo
// Two-entry queue of decoded items between front and back.
// ----------------------------------------------------------------------------
module cuwsm_fifo import cuwsm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t pop_item
);

	item_t       ent_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_item  = ent_q[rd_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

endmodule

// ===== sv/cuwsm_div.sv =====
// ----------------------------------------------------------------------------
// cuwsm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cuwsm_div import cuwsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_DVW-1:0] dividend,
	input  logic [DIV_DSW-1:0] divisor,
	output div_stat_t          stat,
	output logic [DIV_DVW-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_DVW + 1);

	logic [DIV_DSW-1:0] rem_q;
	logic [DIV_DSW-1:0] dsr_q;
	logic [DIV_DVW-1:0] quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_DSW:0]   rem_sh;
	logic               ge;
	logic [DIV_DSW:0]   rem_sub;

	// One trial subtraction.
	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_DVW-1]};
		ge      = (rem_sh >= {1'b0, dsr_q});
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_DVW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DIV_DSW-1:0] : rem_sh[DIV_DSW-1:0];
			quo_q <= {quo_q[DIV_DVW-2:0], ge};
		end
	end

endmodule

// ===== sv/cuwsm_back.sv =====
// ----------------------------------------------------------------------------
// cuwsm_back
// Executes samples and period closes, walks the window, fits the slope.
// ----------------------------------------------------------------------------
`include "cpu_usage_window_slope_monitor_assert.svh"

module cuwsm_back import cuwsm_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  not_empty,
	input  item_t                 pop_item,
	output logic                  pop,
	input  logic [WLEN_W-1:0]     window_length,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int NW = $clog2(MAX_WINDOW + 1);
	localparam int IW = AW + 2;
	localparam int CW = (NW > WLEN_W) ? NW : WLEN_W;
	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	back_state_t state_q, state_d;

	// Model state.
	logic [USAGE_W-1:0] last_usage_q;
	logic [SUM_W-1:0]   freq_sum_q, busy_sum_q, elapsed_sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [AW-1:0]      head_q;
	logic [NW-1:0]      fill_q;
	logic [PCT_W-1:0]   win_mem [MAX_WINDOW];

	// Work registers.
	item_t              it_q;
	logic [USAGE_W-1:0] delta_q;
	logic [PROD_W-1:0]  prod_q, prod_lo_q, t_q;
	logic [SUM_W-1:0]   contrib_q;
	logic [NW-1:0]      n_q;
	logic [AW-1:0]      x_q;
	logic [PCT_W-1:0]   rd_data_q;
	logic [FIT_W-1:0]   sx_q, sy_q, sxy_q, sxx_q;
	logic signed [NUM_W-1:0] num_q, den_q;

	// Result registers.
	logic [AVG_W-1:0]   avg_q;
	logic [SUM_W-1:0]   busy_res_q;
	logic [RATE_W-1:0]  rate_q;
	logic [PCT_W-1:0]   pct_q;
	logic [SLOPE_W-1:0] slope_q;
	logic               valid_q, err_q;

	// Output register.
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	// Shared multiplier and divider hookup.
	logic [MUL_W-1:0]   mul_a, mul_b;
	logic               div_start;
	logic [DIV_DVW-1:0] div_dvd, div_q;
	logic [DIV_DSW-1:0] div_dsr;
	div_stat_t          div_stat;

	logic               out_load;
	logic [IW-1:0]      idx_t;
	logic [AW-1:0]      rd_idx;
	logic [CW-1:0]      wl_e;
	logic [NW-1:0]      n_clamp;
	logic [NUM_W-1:0]   mag;
	logic [SUM_W:0]     fsum_n, bsum_n, esum_n;
	logic [PROD_W-1:0]  pct_full;
	logic [SLOPE_W:0]   smag;
	logic [PROD_W-1:0]  d100;

	cuwsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.stat     (div_stat),
		.quotient (div_q)
	);

	// Window index of fit position x, oldest entry first.
	always_comb begin
		idx_t  = IW'(head_q) + IW'(MAX_WINDOW) - IW'(n_q) + IW'(x_q);
		rd_idx = (idx_t >= IW'(MAX_WINDOW)) ? AW'(idx_t - IW'(MAX_WINDOW)) : AW'(idx_t);
	end

	// Window length clamped to the supported range.
	always_comb begin
		wl_e = CW'(window_length);
		if (wl_e < CW'(2)) begin
			n_clamp = NW'(2);
		end else if (wl_e > CW'(MAX_WINDOW)) begin
			n_clamp = NW'(MAX_WINDOW);
		end else begin
			n_clamp = NW'(wl_e);
		end
	end

	// Saturating accumulator sums and helper values.
	always_comb begin
		fsum_n   = {1'b0, freq_sum_q} + {1'b0, contrib_q};
		bsum_n   = {1'b0, busy_sum_q} + (SUM_W+1)'(delta_q);
		esum_n   = {1'b0, elapsed_sum_q} + (SUM_W+1)'(it_q.elapsed);
		pct_full = prod_q >> RECIP_SHIFT;
		mag      = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
		d100     = prod_q;
		smag     = (div_q > DIV_DVW'(33'h080000000)) ? 33'h080000000 : div_q[SLOPE_W:0];
	end

	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (not_empty) state_d = (pop_item.cmd == CMD_CLOSE) ? ST_C_AVG : ST_S_MLO;
			ST_S_MLO:   state_d = ST_S_MHI;
			ST_S_MHI:   state_d = ST_S_SUM;
			ST_S_SUM:   state_d = it_q.elapsed_zero ? ST_S_UPD : ST_S_WAIT;
			ST_S_WAIT:  if (div_stat.done) state_d = ST_S_UPD;
			ST_S_UPD:   state_d = ST_OUT;
			ST_C_AVG:   state_d = (count_q == '0) ? ST_C_MLO : ST_C_AWAIT;
			ST_C_AWAIT: if (div_stat.done) state_d = ST_C_MLO;
			ST_C_MLO:   state_d = ST_C_MHI;
			ST_C_MHI:   state_d = ST_C_RSUM;
			ST_C_RSUM:  state_d = (elapsed_sum_q == '0) ? ST_C_PCT0 : ST_C_RWAIT;
			ST_C_RWAIT: if (div_stat.done) state_d = ST_C_PCT0;
			ST_C_PCT0:  state_d = ST_C_PCT1;
			ST_C_PCT1:  state_d = ST_C_PUSH;
			ST_C_PUSH:  state_d = ST_C_CHK;
			ST_C_CHK:   state_d = (fill_q >= n_q) ? ST_W_RD : ST_OUT;
			ST_W_RD:    state_d = ST_W_MUL;
			ST_W_MUL:   state_d = ST_W_ACC;
			ST_W_ACC:   state_d = (NW'(x_q) + NW'(1) == n_q) ? ST_F_NUM0 : ST_W_RD;
			ST_F_NUM0:  state_d = ST_F_NUM1;
			ST_F_NUM1:  state_d = ST_F_DEN0;
			ST_F_DEN0:  state_d = ST_F_DEN1;
			ST_F_DEN1:  state_d = ST_F_CHK;
			ST_F_CHK:   state_d = ST_F_DMUL;
			ST_F_DMUL:  state_d = (den_q > 0) ? ST_F_DIV : ST_OUT;
			ST_F_DIV:   state_d = ST_F_WAIT;
			ST_F_WAIT:  if (div_stat.done) state_d = ST_OUT;
			ST_OUT:     if (out_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Multiplier operands, divider requests and queue pop.
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dsr   = '0;
		pop       = 1'b0;
		unique case (state_q)
			ST_IDLE: pop = not_empty;
			ST_S_MLO: begin
				mul_a = MUL_W'(it_q.freq);
				mul_b = MUL_W'(delta_q[19:0]);
			end
			ST_S_MHI: begin
				mul_a = MUL_W'(it_q.freq);
				mul_b = MUL_W'(delta_q[USAGE_W-1:20]);
			end
			ST_S_SUM: begin
				div_start = !it_q.elapsed_zero;
				div_dvd   = (DIV_DVW'(prod_q) << 20) + DIV_DVW'(prod_lo_q);
				div_dsr   = DIV_DSW'(it_q.elapsed);
			end
			ST_C_AVG: begin
				div_start = (count_q != '0);
				div_dvd   = DIV_DVW'(freq_sum_q);
				div_dsr   = DIV_DSW'(count_q);
			end
			ST_C_MLO: begin
				mul_a = MUL_W'(busy_sum_q[23:0]);
				mul_b = US_PER_S;
			end
			ST_C_MHI: begin
				mul_a = MUL_W'(busy_sum_q[SUM_W-1:24]);
				mul_b = US_PER_S;
			end
			ST_C_RSUM: begin
				div_start = (elapsed_sum_q != '0);
				div_dvd   = (DIV_DVW'(prod_q) << 24) + DIV_DVW'(prod_lo_q);
				div_dsr   = elapsed_sum_q;
			end
			ST_C_PCT0: begin
				mul_a = rate_q;
				mul_b = RECIP_100;
			end
			ST_W_MUL: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(rd_data_q);
			end
			ST_F_NUM0: begin
				mul_a = MUL_W'(n_q);
				mul_b = sxy_q;
			end
			ST_F_NUM1: begin
				mul_a = sx_q;
				mul_b = sy_q;
			end
			ST_F_DEN0: begin
				mul_a = MUL_W'(n_q);
				mul_b = sxx_q;
			end
			ST_F_DEN1: begin
				mul_a = sx_q;
				mul_b = sx_q;
			end
			ST_F_DMUL: begin
				mul_a = den_q[MUL_W-1:0];
				mul_b = CENTI;
			end
			ST_F_DIV: begin
				div_start = 1'b1;
				div_dvd   = (DIV_DVW'(mag) << Q16_SHIFT) + DIV_DVW'(d100[MUL_W-1:0]);
				div_dsr   = DIV_DSW'(d100[MUL_W-1:0]) << 1;
			end
			default: ;
		endcase
	end

	// State register and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			last_usage_q  <= '0;
			freq_sum_q    <= '0;
			busy_sum_q    <= '0;
			elapsed_sum_q <= '0;
			count_q       <= '0;
			head_q        <= '0;
			fill_q        <= '0;
			m_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && not_empty && pop_item.cmd == CMD_SAMPLE) begin
				last_usage_q <= pop_item.usage;
			end
			if (state_q == ST_S_UPD) begin
				freq_sum_q    <= fsum_n[SUM_W] ? SUM_MAX : fsum_n[SUM_W-1:0];
				busy_sum_q    <= bsum_n[SUM_W] ? SUM_MAX : bsum_n[SUM_W-1:0];
				elapsed_sum_q <= esum_n[SUM_W] ? SUM_MAX : esum_n[SUM_W-1:0];
				count_q       <= (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 1'b1;
			end
			if (state_q == ST_C_PCT1) begin
				freq_sum_q    <= '0;
				busy_sum_q    <= '0;
				elapsed_sum_q <= '0;
				count_q       <= '0;
			end
			if (state_q == ST_C_PUSH) begin
				head_q <= (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + 1'b1;
				if (fill_q < NW'(MAX_WINDOW)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		case (state_q)
			ST_IDLE: begin
				it_q       <= pop_item;
				delta_q    <= pop_item.usage - last_usage_q;
				avg_q      <= '0;
				busy_res_q <= '0;
				rate_q     <= '0;
				pct_q      <= '0;
				slope_q    <= '0;
				valid_q    <= 1'b0;
				err_q      <= 1'b0;
			end
			ST_S_MHI, ST_C_MHI: prod_lo_q <= prod_q;
			ST_S_SUM: begin
				contrib_q <= '0;
				if (it_q.elapsed_zero) begin
					err_q <= 1'b1;
				end
			end
			ST_S_WAIT: begin
				if (div_stat.done) begin
					contrib_q <= (div_q > DIV_DVW'(SUM_MAX)) ? SUM_MAX : div_q[SUM_W-1:0];
				end
			end
			ST_C_AVG: begin
				if (count_q == '0) begin
					err_q <= 1'b1;
				end
			end
			ST_C_AWAIT: begin
				if (div_stat.done) begin
					avg_q <= (div_q > DIV_DVW'({AVG_W{1'b1}})) ? '1 : div_q[AVG_W-1:0];
				end
			end
			ST_C_RSUM: begin
				if (elapsed_sum_q == '0) begin
					err_q <= 1'b1;
				end
			end
			ST_C_RWAIT: begin
				if (div_stat.done) begin
					rate_q <= (div_q > DIV_DVW'({RATE_W{1'b1}})) ? '1 : div_q[RATE_W-1:0];
				end
			end
			ST_C_PCT1: begin
				pct_q      <= (pct_full > PROD_W'({PCT_W{1'b1}})) ? '1 : pct_full[PCT_W-1:0];
				busy_res_q <= busy_sum_q;
			end
			ST_C_PUSH: begin
				win_mem[head_q] <= pct_q;
				n_q             <= n_clamp;
			end
			ST_C_CHK: begin
				x_q   <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
				sxy_q <= '0;
				sxx_q <= '0;
				if (fill_q >= n_q) begin
					valid_q <= 1'b1;
				end
			end
			ST_W_RD: rd_data_q <= win_mem[rd_idx];
			ST_W_ACC: begin
				sx_q  <= sx_q + FIT_W'(x_q);
				sy_q  <= sy_q + FIT_W'(rd_data_q);
				sxy_q <= sxy_q + prod_q[FIT_W-1:0];
				sxx_q <= sxx_q + FIT_W'(x_q) * FIT_W'(x_q);
				x_q   <= x_q + 1'b1;
			end
			ST_F_NUM1, ST_F_DEN1: t_q <= prod_q;
			ST_F_DEN0: num_q <= $signed(NUM_W'(t_q)) - $signed(NUM_W'(prod_q));
			ST_F_CHK:  den_q <= $signed(NUM_W'(t_q)) - $signed(NUM_W'(prod_q));
			ST_F_WAIT: begin
				if (div_stat.done) begin
					if (num_q[NUM_W-1]) begin
						slope_q <= SLOPE_W'(-smag);
					end else if (smag > 33'h07FFFFFFF) begin
						slope_q <= 32'h7FFFFFFF;
					end else begin
						slope_q <= smag[SLOPE_W-1:0];
					end
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= {slope_q, pct_q, rate_q, busy_res_q, avg_q};
			out_user_q <= {err_q, valid_q, it_q.cmd};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// A slope is only ever reported with a closed period.
	`CUWSM_ASSERT(a_slope_on_close, clk, arst_n, m_valid_q && out_user_q[UB_SLOPE] |-> out_user_q[UB_CLOSED], "slope flagged on a sample result")
	// The fill count never passes the window depth.
	`CUWSM_ASSERT(a_fill_bound, clk, arst_n, fill_q <= NW'(MAX_WINDOW), "window fill overflow")
	// The divider is never restarted while it iterates.
	`CUWSM_NEVER(a_div_overlap, clk, arst_n, div_start && div_stat.busy, "divider started while busy")
	// Sample results carry no rate, percentage or slope.
	`CUWSM_ASSERT(a_sample_clean, clk, arst_n, m_valid_q && !out_user_q[UB_CLOSED] |-> out_data_q[OUT_DATA_W-1:SUM_W+AVG_W] == '0, "sample result carries close fields")

endmodule

// ===== test/tb_cpu_usage_window_slope_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for cpu_usage_window_slope_monitor
// Drives usage samples and period closes with random gaps and output stalls.
// A scoreboard class keeps its own copy of the accumulators and the window
// and checks every result beat, tdata and tuser as a whole, in order.
// ----------------------------------------------------------------------------
module tb_cpu_usage_window_slope_monitor;
	import cuwsm_pkg::*;

	localparam int NWIN       = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam int N_PERIODS  = 22;

	// One expected result beat.
	typedef struct {
		logic        closed;
		logic [23:0] avg;
		logic [47:0] busy;
		logic [31:0] rate;
		logic [15:0] pct;
		logic [31:0] slope;
		logic        slope_ok;
		logic        err;
	} usage_result_t;

	// Predictor of the monitor and store of pending results.
	class usage_scoreboard;
		logic [4:0]  wlen;
		logic [39:0] last_usage;
		logic [47:0] freq_sum, busy_sum, elapsed_sum;
		logic [15:0] n_samples;
		logic [15:0] pct_win [NWIN];
		int          fill, head;
		int          errors;
		usage_result_t pending [$];

		function new();
			wlen = WLEN_RESET;
			last_usage = '0;
			freq_sum = '0;
			busy_sum = '0;
			elapsed_sum = '0;
			n_samples = '0;
			fill = 0;
			head = 0;
			errors = 0;
			foreach (pct_win[i]) pct_win[i] = '0;
		endfunction

		// floor(a*b/d) saturated at lim.
		function logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b,
				logic [63:0] d, logic [63:0] lim);
			logic [127:0] q;
			q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
			return (q > {64'd0, lim}) ? lim : q[63:0];
		endfunction

		function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, logic [63:0] mx);
			if (b >= mx || a >= mx - b) return mx;
			return a + b;
		endfunction

		function logic [31:0] fit_slope(int n);
			longint sx, sy, sxy, sxx, num, den, r;
			logic [63:0] mag, d;
			sx = 0; sy = 0; sxy = 0; sxx = 0;
			for (int x = 0; x < n; x++) begin
				longint y;
				y = pct_win[(head + NWIN - n + x) % NWIN];
				sx += x; sy += y; sxy += x * y; sxx += x * x;
			end
			num = n * sxy - sx * sy;
			den = n * sxx - sx * sx;
			if (den <= 0) return '0;
			d = den * 100;
			mag = (num < 0) ? -num : num;
			mag = (mag * 131072 + d) / (2 * d);
			if (mag > 64'h8000_0000) mag = 64'h8000_0000;
			r = mag;
			if (num < 0) r = -r;
			else if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
			return r[31:0];
		endfunction

		// Notes an accepted input beat and queues its result.
		function void note_item(logic cmd, logic [39:0] usage, logic [31:0] el,
				logic [23:0] fr);
			usage_result_t e;
			logic [63:0] tmp;
			int n;
			e = '{default: '0};
			e.closed = cmd;
			if (cmd == CMD_SAMPLE) begin
				logic [39:0] delta;
				logic [63:0] term;
				delta = usage - last_usage;
				last_usage = usage;
				term = 0;
				if (el == 0) e.err = 1;
				else term = scaled_quot(fr, delta, el, 48'hFFFF_FFFF_FFFF);
				tmp = add_sat(freq_sum, term, 48'hFFFF_FFFF_FFFF);
				freq_sum = tmp[47:0];
				tmp = add_sat(busy_sum, delta, 48'hFFFF_FFFF_FFFF);
				busy_sum = tmp[47:0];
				tmp = add_sat(elapsed_sum, el, 48'hFFFF_FFFF_FFFF);
				elapsed_sum = tmp[47:0];
				tmp = add_sat(n_samples, 1, 16'hFFFF);
				n_samples = tmp[15:0];
			end else begin
				if (n_samples == 0) e.err = 1;
				else begin
					tmp = freq_sum / n_samples;
					e.avg = (tmp > 24'hFF_FFFF) ? 24'hFF_FFFF : tmp[23:0];
				end
				e.busy = busy_sum;
				if (elapsed_sum == 0) e.err = 1;
				else begin
					tmp = scaled_quot(busy_sum, 1000000, elapsed_sum, 32'hFFFF_FFFF);
					e.rate = tmp[31:0];
				end
				tmp = e.rate / 100;
				e.pct = (tmp > 16'hFFFF) ? 16'hFFFF : tmp[15:0];
				freq_sum = 0; busy_sum = 0; elapsed_sum = 0; n_samples = 0;
				pct_win[head] = e.pct;
				head = (head + 1) % NWIN;
				if (fill < NWIN) fill++;
				n = wlen;
				if (n < 2) n = 2;
				if (n > NWIN) n = NWIN;
				if (fill >= n) begin
					e.slope = fit_slope(n);
					e.slope_ok = 1;
				end
			end
			pending = {pending, e};
		endfunction

		// Checks one accepted result beat against the oldest expectation.
		function void check_result(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u);
			usage_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual %h/%h",
					$realtime, d, u);
				errors++;
				return;
			end
			e = pending.pop_front();
			if ({e.slope, e.pct, e.rate, e.busy, e.avg} !== d ||
					{e.err, e.slope_ok, e.closed} !== u) begin
				$display("%0t: result mismatch: expected tdata %h tuser %b, actual tdata %h tuser %b",
					$realtime, {e.slope, e.pct, e.rate, e.busy, e.avg},
					{e.err, e.slope_ok, e.closed}, d, u);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  s_axis_tvalid = 0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  cfg_valid = 0;
	logic                  cfg_ready;
	logic [WLEN_W-1:0]     cfg_data = '0;

	usage_scoreboard sb;
	int  idle_cycles;
	int  out_wait;
	logic [39:0] usage_now;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	cpu_usage_window_slope_monitor u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Sends one item after a random gap and notes it when the beat is taken.
	// The task starts and ends at a falling edge; valid drops only for a gap.
	task automatic send_item(logic cmd, logic [39:0] usage, logic [31:0] el,
			logic [23:0] fr);
		int gap;
		gap = $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {fr, el, usage};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(cmd, usage, el, fr);
		@(negedge clk);
	endtask

	task automatic sample_beat(logic [39:0] usage, logic [31:0] el, logic [23:0] fr);
		usage_now = usage;
		send_item(CMD_SAMPLE, usage, el, fr);
	endtask

	task automatic close_beat();
		send_item(CMD_CLOSE, 40'($urandom()), $urandom(), 24'($urandom()));
	endtask

	// Writes the window length once every pending result has come back.
	task automatic write_wlen(logic [4:0] v);
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		cfg_valid <= 1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.wlen = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// A period of random, mostly realistic samples followed by a close.
	task automatic random_period();
		int ns;
		logic [39:0] u;
		logic [31:0] el;
		logic [23:0] fr;
		ns = $urandom_range(0, 5);
		for (int i = 0; i < ns; i++) begin
			el = $urandom_range(1000, 100000);
			u = usage_now + $urandom_range(0, el);
			fr = 24'($urandom_range(800000, 4000000));
			case ($urandom_range(0, 9))
				0: u = 40'({$urandom(), $urandom()});
				1: el = $urandom();
				2: el = 0;
				3: fr = 24'($urandom());
				default: ;
			endcase
			sample_beat(u, el, fr);
		end
		close_beat();
	endtask

	// Result side: a random wait with tready low before each result beat.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_wait = $urandom_range(0, 15);
			if (out_wait != 0) begin
				m_axis_tready <= 0;
				repeat (out_wait) @(negedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Watchdog on cycles with no accepted beat.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		sb = new();
		idle_cycles = 0;
		usage_now = '0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Close with no samples, zero elapsed, extreme fields.
		close_beat();
		sample_beat(40'd0, 32'd0, 24'd0);
		close_beat();
		sample_beat(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
		sample_beat(40'd5, 32'd1, 24'hFF_FFFF);
		close_beat();
		sample_beat(40'h7F_FFFF_FFFF, 32'd1, 24'hFF_FFFF);
		close_beat();
		sample_beat(40'd100, 32'd1000, 24'd1000000);
		sample_beat(40'd600, 32'd1000, 24'd2000000);
		close_beat();
		for (int i = 0; i < 6; i++) begin
			sample_beat(usage_now + 40'd10 * i, 32'd100, 24'd3000000);
			close_beat();
		end

		// Several window lengths, extremes included.
		begin
			logic [4:0] lens [7];
			lens = '{5'd2, 5'd0, 5'd16, 5'd31, 5'd1, 5'd5, 5'd8};
			for (int k = 0; k < 7; k++) begin
				write_wlen(lens[k]);
				for (int p = 0; p < N_PERIODS; p++) random_period();
			end
		end

		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
